[src/slwps_pkg.sv]
// ----------------------------------------------------------------------------
// slwps_pkg: shared types and constants
// Request codes, command bytes, reset values and the queue entry that
// carries a classified request from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
package slwps_pkg;

	localparam logic [1:0] REQ_REGION = 2'd0;
	localparam logic [1:0] REQ_PIXEL  = 2'd1;
	localparam logic [1:0] REQ_FRAME  = 2'd2;
	localparam logic [1:0] REQ_RSVD   = 2'd3;

	localparam logic [7:0] CMD_CASET = 8'h2a;
	localparam logic [7:0] CMD_RASET = 8'h2b;
	localparam logic [7:0] CMD_RAMWR = 8'h2c;

	localparam logic [1:0] REG_PANEL_W = 2'd0;
	localparam logic [1:0] REG_PANEL_H = 2'd1;

	localparam logic [11:0] PANEL_W_RST = 12'd480;
	localparam logic [11:0] PANEL_H_RST = 12'd272;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        is_pixel;
		logic [15:0] xs;
		logic [15:0] xe;
		logic [15:0] ys;
		logic [15:0] ye;
		logic [7:0]  px_hi;
		logic [7:0]  px_lo;
		logic        rel;
		logic        ovr;
	} entry_t;

endpackage

[src/slwps_front.sv]
// ----------------------------------------------------------------------------
// slwps_front: request front end
// Holds the panel size registers and the pixel countdown, classifies each
// request and pushes a ready-to-send entry into the queue.
// ----------------------------------------------------------------------------
module slwps_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [11:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [15:0]          region_x,
	input  logic [15:0]          region_y,
	input  logic [15:0]          region_w,
	input  logic [15:0]          region_h,
	input  logic [31:0]          pixel_word,
	input  logic                 q_full,
	output logic                 q_push,
	output slwps_pkg::entry_t    q_entry
);

	logic [11:0] panel_w_q;
	logic [11:0] panel_h_q;
	logic [31:0] pixels_left_q;
	logic        accept;
	logic        is_win;
	logic [15:0] wx, wy, ww, wh;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_win   = (req_type == slwps_pkg::REQ_REGION) || (req_type == slwps_pkg::REQ_FRAME);
	assign q_push   = accept && (req_type != slwps_pkg::REQ_RSVD);

	always_comb begin
		if (req_type == slwps_pkg::REQ_FRAME) begin
			wx = 16'd0;
			wy = 16'd0;
			ww = {4'd0, panel_w_q};
			wh = {4'd0, panel_h_q};
		end else begin
			wx = region_x;
			wy = region_y;
			ww = region_w;
			wh = region_h;
		end
	end

	always_comb begin
		q_entry          = '0;
		q_entry.is_pixel = (req_type == slwps_pkg::REQ_PIXEL);
		q_entry.xs       = wx;
		q_entry.xe       = wx + ww - 16'd1;
		q_entry.ys       = wy;
		q_entry.ye       = wy + wh - 16'd1;
		q_entry.px_hi    = {pixel_word[23:19], pixel_word[15:13]};
		q_entry.px_lo    = {pixel_word[12:10], pixel_word[7:3]};
		// select drops after the pixel that empties the window, or on overrun
		q_entry.rel      = (pixels_left_q == 32'd0) || (pixels_left_q == 32'd1);
		q_entry.ovr      = (pixels_left_q == 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_w_q <= slwps_pkg::PANEL_W_RST;
			panel_h_q <= slwps_pkg::PANEL_H_RST;
		end else if (cfg_we) begin
			if (cfg_index == slwps_pkg::REG_PANEL_W) panel_w_q <= cfg_wdata;
			if (cfg_index == slwps_pkg::REG_PANEL_H) panel_h_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= 32'd0;
		end else if (accept) begin
			if (is_win) begin
				pixels_left_q <= {16'd0, ww} * {16'd0, wh};
			end else if (req_type == slwps_pkg::REQ_PIXEL && pixels_left_q != 32'd0) begin
				pixels_left_q <= pixels_left_q - 32'd1;
			end
		end
	end

endmodule

[src/slwps_queue.sv]
// ----------------------------------------------------------------------------
// slwps_queue: entry queue
// Small register FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module slwps_queue #(
	parameter int DEPTH = slwps_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  slwps_pkg::entry_t    wr_entry,
	input  logic                 pop,
	output slwps_pkg::entry_t    rd_entry,
	output logic                 not_empty,
	output logic                 full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	slwps_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + (AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (AW+1)'(1);
		end
	end

endmodule

[src/slwps_back.sv]
// ----------------------------------------------------------------------------
// slwps_back: byte sequencer
// Walks the head entry byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module slwps_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slwps_pkg::entry_t    head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           byte_out,
	output logic                 is_command,
	output logic                 release_select,
	output logic                 overrun,
	output logic                 last
);

	// byte positions inside a window sequence
	localparam logic [3:0] B_CASET = 4'd0;
	localparam logic [3:0] B_XS_HI = 4'd1;
	localparam logic [3:0] B_XS_LO = 4'd2;
	localparam logic [3:0] B_XE_HI = 4'd3;
	localparam logic [3:0] B_XE_LO = 4'd4;
	localparam logic [3:0] B_RASET = 4'd5;
	localparam logic [3:0] B_YS_HI = 4'd6;
	localparam logic [3:0] B_YS_LO = 4'd7;
	localparam logic [3:0] B_YE_HI = 4'd8;
	localparam logic [3:0] B_YE_LO = 4'd9;
	localparam logic [3:0] B_RAMWR = 4'd10;
	localparam logic [3:0] B_PX_LO = 4'd1;

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       cmd_q, rel_q, ovr_q, last_q;
	logic       advance;
	logic       fin;
	logic [7:0] nb;
	logic       ncmd, nrel, novr;

	assign advance = !valid_q || out_ready;
	assign fin     = head.is_pixel ? (idx_q == B_PX_LO) : (idx_q == B_RAMWR);
	assign pop     = advance && head_valid && fin;

	always_comb begin
		ncmd = 1'b0;
		nrel = 1'b1;
		novr = 1'b0;
		nb   = 8'd0;
		if (head.is_pixel) begin
			novr = head.ovr;
			if (idx_q == B_PX_LO) begin
				nb   = head.px_lo;
				nrel = head.rel;
			end else begin
				nb   = head.px_hi;
				nrel = 1'b0;
			end
		end else begin
			unique case (idx_q)
				B_CASET: begin
					nb   = slwps_pkg::CMD_CASET;
					ncmd = 1'b1;
				end
				B_XS_HI: nb = head.xs[15:8];
				B_XS_LO: nb = head.xs[7:0];
				B_XE_HI: nb = head.xe[15:8];
				B_XE_LO: nb = head.xe[7:0];
				B_RASET: begin
					nb   = slwps_pkg::CMD_RASET;
					ncmd = 1'b1;
				end
				B_YS_HI: nb = head.ys[15:8];
				B_YS_LO: nb = head.ys[7:0];
				B_YE_HI: nb = head.ye[15:8];
				B_YE_LO: nb = head.ye[7:0];
				B_RAMWR: begin
					nb   = slwps_pkg::CMD_RAMWR;
					ncmd = 1'b1;
				end
				default: nb = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 4'd0;
		end else if (advance) begin
			valid_q <= head_valid;
			if (head_valid) idx_q <= fin ? 4'd0 : idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			byte_q <= nb;
			cmd_q  <= ncmd;
			rel_q  <= nrel;
			ovr_q  <= novr;
			last_q <= fin;
		end
	end

	assign out_valid      = valid_q;
	assign byte_out       = byte_q;
	assign is_command     = cmd_q;
	assign release_select = rel_q;
	assign overrun        = ovr_q;
	assign last           = last_q;

	a_cmd_rel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_command |-> release_select)
		else $error("command beat without select release");

	a_ovr_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> !is_command)
		else $error("overrun flagged on a command beat");

	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_command && last |-> byte_out == slwps_pkg::CMD_RAMWR)
		else $error("window sequence ends on wrong command");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= B_RAMWR)
		else $error("byte position out of range");

endmodule

[src/spi_lcd_window_pixel_streamer_top.sv]
// ----------------------------------------------------------------------------
// spi_lcd_window_pixel_streamer_top: SPI panel window and pixel byte streamer
// Front end, entry queue and byte sequencer.
// ----------------------------------------------------------------------------
// A region or full-frame request turns into eleven output beats (column
// command, four address bytes, row command, four address bytes, memory write
// command) and loads the pixel countdown; a pixel request turns into two
// RGB565 beats, high byte first. The output register gives one beat per
// cycle while out_ready is held high. The front end takes
// one request per cycle as long as the queue (QUEUE_DEPTH entries) has room,
// also while the output beat is stalled. Request type 3 is dropped silently.
// Panel size registers are written through cfg_we/cfg_index/cfg_wdata.
module spi_lcd_window_pixel_streamer_top #(
	parameter int QUEUE_DEPTH = slwps_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] region_x,
	input  logic [15:0] region_y,
	input  logic [15:0] region_w,
	input  logic [15:0] region_h,
	input  logic [31:0] pixel_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic        is_command,
	output logic        release_select,
	output logic        overrun,
	output logic        last
);

	slwps_pkg::entry_t wr_entry;
	slwps_pkg::entry_t head;
	logic              push, pop, q_full, head_valid;

	slwps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.region_x   (region_x),
		.region_y   (region_y),
		.region_w   (region_w),
		.region_h   (region_h),
		.pixel_word (pixel_word),
		.q_full     (q_full),
		.q_push     (push),
		.q_entry    (wr_entry)
	);

	slwps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (head),
		.not_empty (head_valid),
		.full      (q_full)
	);

	slwps_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_out       (byte_out),
		.is_command     (is_command),
		.release_select (release_select),
		.overrun        (overrun),
		.last           (last)
	);

endmodule

[tb/sv/spi_lcd_window_pixel_streamer_top_tb.sv]
// ----------------------------------------------------------------------------
// spi_lcd_window_pixel_streamer_top_tb: self-checking bench for the window streamer
// Sends region, full-frame and pixel requests and runs its own byte-stream
// predictor: window bytes, RGB565 packing, chip-select release and overrun.
// Each output beat is checked against the oldest expected beat. Both
// handshakes stall at random, and panel size writes land between phases.
// ----------------------------------------------------------------------------
module spi_lcd_window_pixel_streamer_top_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic [7:0] data;
		logic       cmd;
		logic       rel;
		logic       ovr;
		logic       fin;
	} spi_beat_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [15:0] region_x = '0;
	logic [15:0] region_y = '0;
	logic [15:0] region_w = '0;
	logic [15:0] region_h = '0;
	logic [31:0] pixel_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_out;
	logic        is_command;
	logic        release_select;
	logic        overrun;
	logic        last;

	// expected SPI beats, oldest first, plus the predictor's copy of the state
	spi_beat_t   beats_due[$];
	logic [11:0] panel_w_q = slwps_pkg::PANEL_W_RST;
	logic [11:0] panel_h_q = slwps_pkg::PANEL_H_RST;
	logic [31:0] pixels_left_q = '0;

	int errors = 0;
	int cycles = 0;
	int beats_checked = 0;
	int overrun_beats = 0;
	int requests_sent = 0;
	int windows_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	spi_lcd_window_pixel_streamer_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic void expect_beat(logic [7:0] data, logic cmd, logic rel, logic ovr,
			logic fin);
		beats_due.push_back('{data, cmd, rel, ovr, fin});
	endfunction

	function automatic void expect_range(logic [7:0] cmd, logic [15:0] start, logic [15:0] size);
		logic [15:0] stop;
		stop = start + size - 16'd1;	// wraps mod 65536, also for size zero
		expect_beat(cmd, 1'b1, 1'b1, 1'b0, 1'b0);
		expect_beat(start[15:8], 1'b0, 1'b1, 1'b0, 1'b0);
		expect_beat(start[7:0], 1'b0, 1'b1, 1'b0, 1'b0);
		expect_beat(stop[15:8], 1'b0, 1'b1, 1'b0, 1'b0);
		expect_beat(stop[7:0], 1'b0, 1'b1, 1'b0, 1'b0);
	endfunction

	function automatic void expect_window(logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h);
		expect_range(slwps_pkg::CMD_CASET, x, w);
		expect_range(slwps_pkg::CMD_RASET, y, h);
		expect_beat(slwps_pkg::CMD_RAMWR, 1'b1, 1'b1, 1'b0, 1'b1);
		pixels_left_q = {16'd0, w} * {16'd0, h};
		windows_sent++;
	endfunction

	function automatic void expect_pixel(logic [31:0] argb);
		logic [7:0] hi;
		logic [7:0] lo;
		logic       ovr;
		logic       rel;
		hi  = {argb[23:19], argb[15:13]};
		lo  = {argb[12:10], argb[7:3]};
		ovr = (pixels_left_q == 32'd0);
		rel = ovr;
		if (!ovr) begin
			pixels_left_q = pixels_left_q - 32'd1;
			rel = (pixels_left_q == 32'd0);
		end
		expect_beat(hi, 1'b0, 1'b0, ovr, 1'b0);
		expect_beat(lo, 1'b0, rel, ovr, 1'b1);
	endfunction

	function automatic void predict_request(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h, logic [31:0] argb);
		case (kind)
			slwps_pkg::REQ_REGION: expect_window(x, y, w, h);
			slwps_pkg::REQ_FRAME: expect_window(16'd0, 16'd0, {4'd0, panel_w_q},
				{4'd0, panel_h_q});
			slwps_pkg::REQ_PIXEL: expect_pixel(argb);
			default: ;
		endcase
	endfunction

	// ---------------- request side ----------------
	task automatic issue_request(input logic [1:0] kind, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] w, input logic [15:0] h,
			input logic [31:0] argb);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid   <= 1'b1;
		req_type   <= kind;
		region_x   <= x;
		region_y   <= y;
		region_w   <= w;
		region_h   <= h;
		pixel_word <= argb;
		do @(posedge clk); while (!in_ready);
		predict_request(kind, x, y, w, h, argb);
		if (kind != slwps_pkg::REQ_RSVD)
			requests_sent++;
	endtask

	task automatic send_region(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
			input logic [15:0] h);
		issue_request(slwps_pkg::REQ_REGION, x, y, w, h, $urandom());
	endtask

	task automatic send_frame();
		issue_request(slwps_pkg::REQ_FRAME, 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), $urandom());
	endtask

	task automatic send_pixel(input logic [31:0] argb);
		issue_request(slwps_pkg::REQ_PIXEL, 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), argb);
	endtask

	task automatic send_pixels(input int n);
		repeat (n) send_pixel($urandom());
	endtask

	// hold the sender until every expected beat is out, then let the pipe settle
	task automatic drain_stream();
		in_valid <= 1'b0;
		burst_left = 0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_panel(input logic [1:0] index, input logic [11:0] value);
		drain_stream();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == slwps_pkg::REG_PANEL_W)
			panel_w_q = value;
		else
			panel_h_q = value;
	endtask

	// ---------------- result side ----------------
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(30, 150);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_phase % 4 != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic string beat_text(spi_beat_t b);
		return $sformatf("byte %02h cmd %b rel %b ovr %b last %b",
			b.data, b.cmd, b.rel, b.ovr, b.fin);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("ERROR cycle %0d: %s", cycles, what);
	endtask

	always @(posedge clk) begin : check_beats
		spi_beat_t got;
		spi_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{byte_out, is_command, release_select, overrun, last};
			beats_checked++;
			if (got.ovr)
				overrun_beats++;
			if (beats_due.size() == 0) begin
				report_mismatch({"unexpected beat: ", beat_text(got)});
			end else begin
				want = beats_due.pop_front();
				if (got.data !== want.data || got.cmd !== want.cmd || got.rel !== want.rel
						|| got.ovr !== want.ovr || got.fin !== want.fin)
					report_mismatch({"got ", beat_text(got), " want ", beat_text(want)});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout with %0d beats outstanding", beats_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------- tests ----------------
	task automatic test_window_edges();
		send_region(16'h0000, 16'h0000, 16'h0001, 16'h0001);
		send_pixel(32'h0000_0000);
		// end address wraps past 0xffff
		send_region(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_pixel(32'hffff_ffff);
		// zero size: end is start - 1 and the countdown is empty
		send_region(16'h1234, 16'h00ff, 16'h0000, 16'h0000);
		send_pixel(32'hffff_ffff);
		issue_request(slwps_pkg::REQ_RSVD, 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), $urandom());
	endtask

	task automatic test_pixel_packing();
		send_region(16'd5, 16'd7, 16'd2, 16'd2);
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h00ff_0000);
		send_pixel(32'h0000_ff00);
		send_pixel(32'h0000_00ff);	// one past the window: overrun
		// new window cuts off an open pixel transfer
		send_region(16'd0, 16'd0, 16'd3, 16'd1);
		send_pixel(32'haa55_aa55);
		send_region(16'd1, 16'd1, 16'd1, 16'd2);
		send_pixels(2);
	endtask

	task automatic test_frame_sizes();
		send_frame();
		send_pixel($urandom());
		write_panel(slwps_pkg::REG_PANEL_W, 12'd1);
		write_panel(slwps_pkg::REG_PANEL_H, 12'd1);
		send_frame();
		send_pixels(2);
		write_panel(slwps_pkg::REG_PANEL_W, 12'd4095);
		write_panel(slwps_pkg::REG_PANEL_H, 12'd4095);
		send_frame();
		send_pixel($urandom());
	endtask

	task automatic test_random_traffic(input int target);
		int          start;
		int          span;
		logic [15:0] w;
		logic [15:0] h;
		for (int quarter = 0; quarter < 4; quarter++) begin
			// each quarter gets its own panel size; the third one is full range
			if (quarter == 2) begin
				write_panel(slwps_pkg::REG_PANEL_W, 12'($urandom_range(1, 4095)));
				write_panel(slwps_pkg::REG_PANEL_H, 12'($urandom_range(1, 4095)));
			end else begin
				write_panel(slwps_pkg::REG_PANEL_W, 12'($urandom_range(1, 4)));
				write_panel(slwps_pkg::REG_PANEL_H, 12'($urandom_range(1, 4)));
			end
			start = requests_sent;
			while (requests_sent - start < target / 4) begin
				if ($urandom_range(0, 9) < 7) begin
					if ($urandom_range(0, 2) != 0) begin
						w = ($urandom_range(0, 9) == 0) ? 16'($urandom())
							: 16'($urandom_range(1, 4));
						h = ($urandom_range(0, 9) == 0) ? 16'($urandom())
							: 16'($urandom_range(1, 4));
						send_region(16'($urandom()), 16'($urandom()), w, h);
					end else begin
						send_frame();
					end
					span = (pixels_left_q > 32'd16) ? int'($urandom_range(0, 3))
						: int'(pixels_left_q);
					case ($urandom_range(0, 4))
						0: if (span > 0) span--;	// leave the window open
						1: span++;			// run past the end
						default: ;
					endcase
					send_pixels(span);
				end else begin
					issue_request(2'($urandom_range(0, 3)), 16'($urandom()),
						16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_window_edges();
		test_pixel_packing();
		test_frame_sizes();
		test_random_traffic(120);
		drain_stream();
		$display("Covered %0d requests (%0d windows) giving %0d beats, %0d with overrun set.",
			requests_sent, windows_sent, beats_checked, overrun_beats);
		$display("Panel sizes ran at reset, 1x1, 4095x4095 and random values under stalls.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
